FILE: design/rpc_pkg.sv
`default_nettype none
package rpc_pkg;

    localparam int NSTAGE = 4;
    localparam int CW     = 32;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_BOTTOM = 2'd1;
    localparam logic [1:0] REG_RIGHT  = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

    // Clip stage codes.
    localparam logic [1:0] STG_LEFT   = 2'd0;
    localparam logic [1:0] STG_RIGHT  = 2'd1;
    localparam logic [1:0] STG_BOTTOM = 2'd2;
    localparam logic [1:0] STG_TOP    = 2'd3;

    // Stage number that means "past the last clip stage".
    localparam logic [2:0] STG_OUT = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CROSS,
        S_CLOSE,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        X_IDLE,
        X_MUL0,
        X_MUL1,
        X_DIV
    } t_xph;

    typedef struct packed {
        logic       load;
        logic       eval;
        logic       pop;
        logic       emit;
        logic       take;
        logic       close_cross;
        logic       close_skip;
        logic       fin;
        logic [1:0] k;
    } t_cmd;

    typedef struct packed {
        logic at_out;
        logic cin;
        logic cross_need;
        logic stack_empty;
        logic emit_ok;
        logic fin_ok;
        logic close_cross;
        logic xdone;
    } t_sts;

    function automatic logic inside_win(
        input logic [1:0]           s,
        input logic signed [CW-1:0] x,
        input logic signed [CW-1:0] y,
        input logic signed [CW-1:0] wl,
        input logic signed [CW-1:0] wr,
        input logic signed [CW-1:0] wb,
        input logic signed [CW-1:0] wt
    );
        logic res;
        unique case (s)
            STG_LEFT:   res = (x >= wl);
            STG_RIGHT:  res = (x <= wr);
            STG_BOTTOM: res = (y >= wb);
            default:    res = (y <= wt);
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: design/rpc_xunit.sv
`default_nettype none
module rpc_xunit
    import rpc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic signed [CW-1:0]  i_au,
    input  wire logic signed [CW-1:0]  i_av,
    input  wire logic signed [CW-1:0]  i_bu,
    input  wire logic signed [CW-1:0]  i_bv,
    input  wire logic signed [CW-1:0]  i_bound,
    output logic                       o_done,
    output logic signed [CW-1:0]       o_res
);
    // Computes av + (bv-av)*(bound-au)/(bu-au), truncated toward zero:
    // one 33x17 and one 33x16 partial product, then a 33-step restoring divide.
    localparam int MW = CW + 1;

    t_xph r_ph, n_ph;
    logic [5:0]     r_cnt;
    logic           r_done;
    logic [MW-1:0]  r_mdv, r_mt, r_mdu;
    logic           r_neg, r_zero;
    logic signed [CW-1:0] r_av;
    logic [2*MW-1:0] r_p;
    logic [MW:0]    r_rem;
    logic [MW-1:0]  r_lo;

    logic signed [MW-1:0] du, dv, dt;
    logic [MW-1:0] mdu, mdv, mt;
    logic [2*MW-1:0] p_hi, p_full;
    logic [MW:0]   rem_sh, rem_sub;
    logic signed [MW+1:0] sum;

    assign du  = $signed({i_bu[CW-1], i_bu}) - $signed({i_au[CW-1], i_au});
    assign dv  = $signed({i_bv[CW-1], i_bv}) - $signed({i_av[CW-1], i_av});
    assign dt  = $signed({i_bound[CW-1], i_bound}) - $signed({i_au[CW-1], i_au});
    assign mdu = du[MW-1] ? MW'(-du) : MW'(du);
    assign mdv = dv[MW-1] ? MW'(-dv) : MW'(dv);
    assign mt  = dt[MW-1] ? MW'(-dt) : MW'(dt);

    assign p_hi   = (2*MW)'(r_mdv * r_mt[MW-1:17]) << 17;
    assign p_full = r_p + p_hi;

    assign rem_sh  = {r_rem[MW-1:0], r_lo[MW-1]};
    assign rem_sub = rem_sh - {1'b0, r_mdu};

    assign sum = r_neg ? ($signed({{2{r_av[CW-1]}}, r_av}) - $signed({2'b00, r_lo}))
                       : ($signed({{2{r_av[CW-1]}}, r_av}) + $signed({2'b00, r_lo}));

    always_comb begin
        if (r_zero) begin
            o_res = r_av;
        end else if (sum > $signed({{3{1'b0}}, {(CW-1){1'b1}}})) begin
            o_res = {1'b0, {(CW-1){1'b1}}};
        end else if (sum < $signed({{3{1'b1}}, {(CW-1){1'b0}}})) begin
            o_res = {1'b1, {(CW-1){1'b0}}};
        end else begin
            o_res = sum[CW-1:0];
        end
    end
    assign o_done = r_done;

    always_comb begin
        n_ph = r_ph;
        unique case (r_ph)
            X_IDLE: if (i_start) n_ph = X_MUL0;
            X_MUL0: n_ph = X_MUL1;
            X_MUL1: n_ph = X_DIV;
            X_DIV:  if (r_cnt == 6'd0) n_ph = X_IDLE;
            default: n_ph = X_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= X_IDLE;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_ph <= n_ph;
            if (i_start) r_done <= 1'b0;
            if (r_ph == X_MUL1) r_cnt <= 6'(MW - 1);
            else if (r_ph == X_DIV && r_cnt != 6'd0) r_cnt <= r_cnt - 6'd1;
            if (r_ph == X_DIV && r_cnt == 6'd0) r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ph == X_IDLE && i_start) begin
            r_mdv  <= mdv;
            r_mt   <= mt;
            r_mdu  <= mdu;
            r_neg  <= dv[MW-1] ^ dt[MW-1] ^ du[MW-1];
            r_zero <= (du == '0);
            r_av   <= i_av;
        end
        if (r_ph == X_MUL0) r_p <= (2*MW)'(r_mdv * r_mt[16:0]);
        if (r_ph == X_MUL1) begin
            r_rem <= {1'b0, p_full[2*MW-1:MW]};
            r_lo  <= p_full[MW-1:0];
        end
        if (r_ph == X_DIV) begin
            if (!rem_sub[MW]) begin
                r_rem <= rem_sub;
                r_lo  <= {r_lo[MW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_lo  <= {r_lo[MW-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

FILE: design/rpc_dp.sv
`default_nettype none
module rpc_dp
    import rpc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_sts                      o_sts,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [CW-1:0]        i_cfg_data,
    input  wire logic signed [CW-1:0] i_vertex_x,
    input  wire logic signed [CW-1:0] i_vertex_y,
    input  wire logic                 i_final_vertex,
    input  wire logic                 i_stall,
    output logic                      o_valid,
    output logic signed [CW-1:0]      o_clipped_x,
    output logic signed [CW-1:0]      o_clipped_y,
    output logic                      o_polygon_end,
    output logic                      o_polygon_empty
);
    logic signed [CW-1:0] r_wl, r_wb, r_wr, r_wt;
    logic signed [CW-1:0] r_fx [NSTAGE];
    logic signed [CW-1:0] r_fy [NSTAGE];
    logic signed [CW-1:0] r_px [NSTAGE];
    logic signed [CW-1:0] r_py [NSTAGE];
    logic [NSTAGE-1:0]    r_started;

    logic [2:0]           r_cs;
    logic signed [CW-1:0] r_cx, r_cy;
    logic                 r_lastv;
    logic [2:0]           r_xstage;
    logic signed [CW-1:0] r_xbound;

    logic [2:0]           r_stk_s [NSTAGE];
    logic signed [CW-1:0] r_stk_x [NSTAGE];
    logic signed [CW-1:0] r_stk_y [NSTAGE];
    logic [2:0]           r_sp;

    logic                 r_hv, r_any;
    logic signed [CW-1:0] r_hx, r_hy;
    logic                 r_ov, r_oend, r_oempty;
    logic signed [CW-1:0] r_ox, r_oy;

    logic [1:0] s;
    logic       cin, pin, started, fin_k, pin_k, out_free;
    logic [1:0] xs;
    logic signed [CW-1:0] ax, ay, bx, by, xbound;
    logic       xstart;
    logic       xdone;
    logic signed [CW-1:0] xres;
    logic [1:0] sp_top;

    assign s       = r_cs[1:0];
    assign cin     = inside_win(s, r_cx, r_cy, r_wl, r_wr, r_wb, r_wt);
    assign pin     = inside_win(s, r_px[s], r_py[s], r_wl, r_wr, r_wb, r_wt);
    assign started = r_started[s];
    assign fin_k   = inside_win(i_cmd.k, r_fx[i_cmd.k], r_fy[i_cmd.k], r_wl, r_wr, r_wb, r_wt);
    assign pin_k   = inside_win(i_cmd.k, r_px[i_cmd.k], r_py[i_cmd.k], r_wl, r_wr, r_wb, r_wt);
    assign out_free = !r_ov || !i_stall;
    assign sp_top  = 2'(r_sp - 3'd1);

    assign o_sts.at_out      = (r_cs == STG_OUT);
    assign o_sts.cin         = cin;
    assign o_sts.cross_need  = started && (cin != pin);
    assign o_sts.stack_empty = (r_sp == 3'd0);
    assign o_sts.emit_ok     = (r_lastv && !r_hv) || out_free;
    assign o_sts.fin_ok      = out_free;
    assign o_sts.close_cross = r_started[i_cmd.k] && (fin_k != pin_k);
    assign o_sts.xdone       = xdone;

    // Crossing operands: previous vertex to current, or to first on close.
    always_comb begin
        if (i_cmd.close_cross) begin
            xs = i_cmd.k;
            ax = r_px[i_cmd.k];
            ay = r_py[i_cmd.k];
            bx = r_fx[i_cmd.k];
            by = r_fy[i_cmd.k];
        end else begin
            xs = s;
            ax = r_px[s];
            ay = r_py[s];
            bx = r_cx;
            by = r_cy;
        end
        unique case (xs)
            STG_LEFT:   xbound = r_wl;
            STG_RIGHT:  xbound = r_wr;
            STG_BOTTOM: xbound = r_wb;
            default:    xbound = r_wt;
        endcase
    end

    assign xstart = i_cmd.close_cross || (i_cmd.eval && o_sts.cross_need);

    rpc_xunit u_xunit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (xstart),
        .i_au    (xs[1] ? ay : ax),
        .i_av    (xs[1] ? ax : ay),
        .i_bu    (xs[1] ? by : bx),
        .i_bv    (xs[1] ? bx : by),
        .i_bound (xbound),
        .o_done  (xdone),
        .o_res   (xres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl      <= 32'sd3276800;
            r_wb      <= 32'sd3276800;
            r_wr      <= 32'sd19660800;
            r_wt      <= 32'sd19660800;
            r_started <= '0;
            r_sp      <= '0;
            r_hv      <= 1'b0;
            r_any     <= 1'b0;
            r_ov      <= 1'b0;
            for (int i = 0; i < NSTAGE; i++) begin
                r_fx[i] <= '0;
                r_fy[i] <= '0;
                r_px[i] <= '0;
                r_py[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_LEFT:   r_wl <= i_cfg_data;
                    REG_BOTTOM: r_wb <= i_cfg_data;
                    REG_RIGHT:  r_wr <= i_cfg_data;
                    default:    r_wt <= i_cfg_data;
                endcase
            end
            if (r_ov && !i_stall) r_ov <= 1'b0;

            if (i_cmd.eval) begin
                if (!started) begin
                    r_started[s] <= 1'b1;
                    r_fx[s] <= r_cx;
                    r_fy[s] <= r_cy;
                end else if (cin != pin && cin) begin
                    r_stk_s[r_sp[1:0]] <= r_cs + 3'd1;
                    r_stk_x[r_sp[1:0]] <= r_cx;
                    r_stk_y[r_sp[1:0]] <= r_cy;
                    r_sp <= r_sp + 3'd1;
                end
                r_px[s] <= r_cx;
                r_py[s] <= r_cy;
            end
            if (i_cmd.pop) r_sp <= r_sp - 3'd1;
            if (i_cmd.close_cross || i_cmd.close_skip) r_started[i_cmd.k] <= 1'b0;

            // Only the final vertex holds back one result so the end mark can go on it.
            if (i_cmd.emit) begin
                r_any <= 1'b1;
                if (r_lastv) begin
                    r_hv <= 1'b1;
                    if (r_hv) r_ov <= 1'b1;
                end else begin
                    r_ov <= 1'b1;
                end
            end
            if (i_cmd.fin) begin
                r_any <= 1'b0;
                r_hv  <= 1'b0;
                r_ov  <= r_hv || !r_any;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cs    <= '0;
            r_cx    <= i_vertex_x;
            r_cy    <= i_vertex_y;
            r_lastv <= i_final_vertex;
        end
        if (i_cmd.eval && cin && !(started && cin != pin)) r_cs <= r_cs + 3'd1;
        if (xstart) begin
            r_xstage <= {1'b0, xs} + 3'd1;
            r_xbound <= xbound;
        end
        if (i_cmd.take) begin
            r_cs <= r_xstage;
            if (r_xstage[2] || r_xstage[1]) begin
                // Right crossings: y is interpolated; bottom and top crossings: x is interpolated.
                r_cx <= (r_xstage == 3'd2) ? r_xbound : xres;
                r_cy <= (r_xstage == 3'd2) ? xres : r_xbound;
            end else begin
                r_cx <= r_xbound;
                r_cy <= xres;
            end
        end
        if (i_cmd.pop) begin
            r_cs <= r_stk_s[sp_top];
            r_cx <= r_stk_x[sp_top];
            r_cy <= r_stk_y[sp_top];
        end
        if (i_cmd.emit) begin
            if (r_lastv) begin
                r_hx <= r_cx;
                r_hy <= r_cy;
                if (r_hv) begin
                    r_ox     <= r_hx;
                    r_oy     <= r_hy;
                    r_oend   <= 1'b0;
                    r_oempty <= 1'b0;
                end
            end else begin
                r_ox     <= r_cx;
                r_oy     <= r_cy;
                r_oend   <= 1'b0;
                r_oempty <= 1'b0;
            end
        end
        // Results given by earlier vertices leave nothing to mark at the end.
        if (i_cmd.fin && (r_hv || !r_any)) begin
            r_oend   <= 1'b1;
            r_oempty <= !r_hv;
            r_ox     <= r_hv ? r_hx : '0;
            r_oy     <= r_hv ? r_hy : '0;
        end
    end

    assign o_valid         = r_ov;
    assign o_clipped_x     = r_ox;
    assign o_clipped_y     = r_oy;
    assign o_polygon_end   = r_oend;
    assign o_polygon_empty = r_oempty;
endmodule
`default_nettype wire

FILE: design/rpc_ctrl.sv
`default_nettype none
module rpc_ctrl
    import rpc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire logic i_final_vertex,
    output logic      o_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    t_state r_state, n_state;
    logic   r_last, n_last;
    logic   r_closing, n_closing;
    logic [2:0] r_k, n_k;

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_last    <= 1'b0;
            r_closing <= 1'b0;
            r_k       <= '0;
        end else begin
            r_state   <= n_state;
            r_last    <= n_last;
            r_closing <= n_closing;
            r_k       <= n_k;
        end
    end

    always_comb begin
        logic chain_end;
        chain_end = 1'b0;
        n_state   = r_state;
        n_last    = r_last;
        n_closing = r_closing;
        n_k       = r_k;
        o_cmd     = '0;
        o_cmd.k   = r_k[1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_last     = i_final_vertex;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.at_out) begin
                    if (i_sts.emit_ok) begin
                        o_cmd.emit = 1'b1;
                        chain_end  = 1'b1;
                    end
                end else begin
                    o_cmd.eval = 1'b1;
                    if (i_sts.cross_need) n_state = S_CROSS;
                    else if (!i_sts.cin) chain_end = 1'b1;
                end
            end
            S_CROSS: begin
                if (i_sts.xdone) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_CLOSE: begin
                if (r_k == STG_OUT) begin
                    n_state = S_FIN;
                end else if (i_sts.close_cross) begin
                    o_cmd.close_cross = 1'b1;
                    n_state           = S_CROSS;
                end else begin
                    o_cmd.close_skip = 1'b1;
                    n_k              = r_k + 3'd1;
                end
            end
            S_FIN: begin
                if (i_sts.fin_ok) begin
                    o_cmd.fin = 1'b1;
                    n_closing = 1'b0;
                    n_last    = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // A chain of pushes has ended: resume a held vertex, the close sweep,
        // or finish the item.
        if (chain_end) begin
            if (!i_sts.stack_empty) begin
                o_cmd.pop = 1'b1;
                n_state   = S_EVAL;
            end else if (r_closing) begin
                n_k     = r_k + 3'd1;
                n_state = S_CLOSE;
            end else if (r_last) begin
                n_closing = 1'b1;
                n_k       = '0;
                n_state   = S_CLOSE;
            end else begin
                n_state = S_IDLE;
            end
        end
    end
endmodule
`default_nettype wire

FILE: design/rect_polygon_clipper.sv
// Each vertex passes the clip stages it reaches and is then emitted; each crossing
// runs in the shared multiply/divide unit (multiply, restoring divide, then take).
// One vertex is taken at a time: o_stall stays high until its stages, crossings and
// any output stalls are done; a final vertex adds a close sweep and up to 4 closing
// crossings.
// Reset (i_rst_n low, synchronous) clears stage state, restores the default window.
`default_nettype none
module rect_polygon_clipper
    import rpc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [CW-1:0]        i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic signed [CW-1:0] i_vertex_x,
    input  wire logic signed [CW-1:0] i_vertex_y,
    input  wire logic                 i_final_vertex,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic signed [CW-1:0]      o_clipped_x,
    output logic signed [CW-1:0]      o_clipped_y,
    output logic                      o_polygon_end,
    output logic                      o_polygon_empty
);
    t_cmd cmd;
    t_sts sts;

    rpc_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_final_vertex (i_final_vertex),
        .o_stall        (o_stall),
        .i_sts          (sts),
        .o_cmd          (cmd)
    );

    rpc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_vertex_x      (i_vertex_x),
        .i_vertex_y      (i_vertex_y),
        .i_final_vertex  (i_final_vertex),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_clipped_x     (o_clipped_x),
        .o_clipped_y     (o_clipped_y),
        .o_polygon_end   (o_polygon_end),
        .o_polygon_empty (o_polygon_empty)
    );
endmodule
`default_nettype wire

FILE: design/rpc_checker.sv
`default_nettype none
module rpc_checker
    import rpc_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_valid,
    input wire logic                 o_stall,
    input wire logic                 o_valid,
    input wire logic                 i_stall,
    input wire logic signed [CW-1:0] o_clipped_x,
    input wire logic signed [CW-1:0] o_clipped_y,
    input wire logic                 o_polygon_end,
    input wire logic                 o_polygon_empty
);
    // The input stalls in the cycle after every vertex beat is taken.
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken back to back");

    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_polygon_empty) |-> o_polygon_end)
        else $error("empty result without end mark");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_polygon_empty) |-> (o_clipped_x == '0 && o_clipped_y == '0))
        else $error("empty result with nonzero coordinates");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_clipped_x) && $stable(o_clipped_y)))
        else $error("stalled output beat changed");
endmodule

bind rect_polygon_clipper rpc_checker u_rpc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_clipped_x     (o_clipped_x),
    .o_clipped_y     (o_clipped_y),
    .o_polygon_end   (o_polygon_end),
    .o_polygon_empty (o_polygon_empty)
);
`default_nettype wire

FILE: verif/rect_polygon_clipper_tb.sv
`timescale 1ns / 100ps
module rect_polygon_clipper_tb;
    import rpc_pkg::*;

    localparam int  LIMIT      = 2000000;
    localparam int  SETTLE     = 300;
    localparam int  RAND_ITEMS = 305;
    localparam logic signed [CW-1:0] MAXC = 32'sh7fffffff;
    localparam logic signed [CW-1:0] MINC = 32'sh80000000;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 last;
        logic                 empty;
    } clip_beat_t;

    typedef struct {
        int                   stg;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } pend_vtx_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [1:0]           i_cfg_index;
    logic [CW-1:0]        i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic signed [CW-1:0] i_vertex_x;
    logic signed [CW-1:0] i_vertex_y;
    logic                 i_final_vertex;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [CW-1:0] o_clipped_x;
    logic signed [CW-1:0] o_clipped_y;
    logic                 o_polygon_end;
    logic                 o_polygon_empty;

    rect_polygon_clipper DUT (.*);

    // Predictor state.
    logic signed [CW-1:0] win_left, win_bottom, win_right, win_top;
    logic signed [CW-1:0] stg_first_x [NSTAGE];
    logic signed [CW-1:0] stg_first_y [NSTAGE];
    logic signed [CW-1:0] stg_prev_x [NSTAGE];
    logic signed [CW-1:0] stg_prev_y [NSTAGE];
    logic                 stg_started [NSTAGE];
    logic                 any_out;
    pend_vtx_t            pending [$];
    clip_beat_t           poly_out [$];
    clip_beat_t           expected_beats [$];

    int  errors;
    int  cycles;
    int  items_sent;
    bit  calm;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("%0t timeout", $time);
            $display("rect_polygon_clipper: mismatch");
            $finish;
        end
    end

    function automatic logic in_window(int s, logic signed [CW-1:0] x,
                                       logic signed [CW-1:0] y);
        case (s)
            STG_LEFT:   return x >= win_left;
            STG_RIGHT:  return x <= win_right;
            STG_BOTTOM: return y >= win_bottom;
            default:    return y <= win_top;
        endcase
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Other-axis coordinate at the boundary, quotient truncated toward zero.
    function automatic logic signed [CW-1:0] edge_cross(
        logic signed [CW-1:0] au, logic signed [CW-1:0] av,
        logic signed [CW-1:0] bu, logic signed [CW-1:0] bv,
        logic signed [CW-1:0] bound);
        longint      du, dv, t, r;
        logic [63:0] q;
        logic        neg;
        du = longint'(bu) - longint'(au);
        dv = longint'(bv) - longint'(av);
        t  = longint'(bound) - longint'(au);
        if (du == 0)
            return av;
        q   = (magnitude(dv) * magnitude(t)) / magnitude(du);
        neg = ((dv < 0) != (t < 0)) != (du < 0);
        r   = neg ? longint'(av) - longint'(q) : longint'(av) + longint'(q);
        if (r > longint'(MAXC)) r = longint'(MAXC);
        if (r < longint'(MINC)) r = longint'(MINC);
        return r[CW-1:0];
    endfunction

    function automatic pend_vtx_t cross_into_next(int s, logic signed [CW-1:0] px,
        logic signed [CW-1:0] py, logic signed [CW-1:0] cx, logic signed [CW-1:0] cy);
        pend_vtx_t            p;
        logic signed [CW-1:0] bound;
        p.stg = s + 1;
        if (s < 2) begin
            bound = (s == 0) ? win_left : win_right;
            p.x   = bound;
            p.y   = edge_cross(px, py, cx, cy, bound);
        end else begin
            bound = (s == 2) ? win_bottom : win_top;
            p.x   = edge_cross(py, px, cy, cx, bound);
            p.y   = bound;
        end
        return p;
    endfunction

    // Depth first: a crossing is pushed after the vertex so it leaves first.
    task automatic run_stages();
        pend_vtx_t  p;
        clip_beat_t b;
        logic       cin, pin;
        while (pending.size() > 0) begin
            p = pending.pop_back();
            if (p.stg >= NSTAGE) begin
                any_out = 1'b1;
                if (poly_out.size() < 16) begin
                    b.x = p.x; b.y = p.y; b.last = 1'b0; b.empty = 1'b0;
                    poly_out.insert(poly_out.size(), b);
                end
            end else begin
                cin = in_window(p.stg, p.x, p.y);
                if (!stg_started[p.stg]) begin
                    stg_started[p.stg] = 1'b1;
                    stg_first_x[p.stg] = p.x;
                    stg_first_y[p.stg] = p.y;
                    stg_prev_x[p.stg]  = p.x;
                    stg_prev_y[p.stg]  = p.y;
                    if (cin)
                        pending.insert(pending.size(), pend_vtx_t'{p.stg + 1, p.x, p.y});
                end else begin
                    pin = in_window(p.stg, stg_prev_x[p.stg], stg_prev_y[p.stg]);
                    if (cin)
                        pending.insert(pending.size(), pend_vtx_t'{p.stg + 1, p.x, p.y});
                    if (cin != pin)
                        pending.insert(pending.size(), cross_into_next(p.stg,
                            stg_prev_x[p.stg], stg_prev_y[p.stg], p.x, p.y));
                    stg_prev_x[p.stg] = p.x;
                    stg_prev_y[p.stg] = p.y;
                end
            end
        end
    endtask

    task automatic predict_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                  logic fin);
        clip_beat_t b;
        logic       fin_in, prev_in;
        poly_out.delete();
        pending.insert(pending.size(), pend_vtx_t'{0, x, y});
        run_stages();
        if (fin) begin
            for (int s = 0; s < NSTAGE; s++) begin
                if (stg_started[s]) begin
                    fin_in  = in_window(s, stg_first_x[s], stg_first_y[s]);
                    prev_in = in_window(s, stg_prev_x[s], stg_prev_y[s]);
                    if (fin_in != prev_in)
                        pending.insert(pending.size(), cross_into_next(s, stg_prev_x[s],
                            stg_prev_y[s], stg_first_x[s], stg_first_y[s]));
                    stg_started[s] = 1'b0;
                    run_stages();
                end
            end
            if (!any_out) begin
                b.x = '0; b.y = '0; b.last = 1'b1; b.empty = 1'b1;
                poly_out.insert(poly_out.size(), b);
            end else if (poly_out.size() > 0) begin
                poly_out[poly_out.size() - 1].last = 1'b1;
            end
            any_out = 1'b0;
        end
        foreach (poly_out[k])
            expected_beats.insert(expected_beats.size(), poly_out[k]);
    endtask

    // Result checker and receiver stall generator.
    always @(posedge i_clk) begin
        clip_beat_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_beats.size() == 0) begin
                errors++;
                $display("%0t unexpected beat: got x=%0d y=%0d end=%0b empty=%0b",
                         $time, o_clipped_x, o_clipped_y, o_polygon_end, o_polygon_empty);
            end else begin
                e = expected_beats.pop_front();
                if (o_clipped_x !== e.x) begin
                    errors++;
                    $display("%0t clipped_x: expected %0d, got %0d", $time, e.x, o_clipped_x);
                end
                if (o_clipped_y !== e.y) begin
                    errors++;
                    $display("%0t clipped_y: expected %0d, got %0d", $time, e.y, o_clipped_y);
                end
                if (o_polygon_end !== e.last) begin
                    errors++;
                    $display("%0t polygon_end: expected %0b, got %0b", $time, e.last,
                             o_polygon_end);
                end
                if (o_polygon_empty !== e.empty) begin
                    errors++;
                    $display("%0t polygon_empty: expected %0b, got %0b", $time, e.empty,
                             o_polygon_empty);
                end
            end
        end
    end

    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            n = calm ? 0 : $urandom_range(0, 10);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    task automatic send_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                               logic fin);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_vertex_x     <= x;
        i_vertex_y     <= y;
        i_final_vertex <= fin;
        do @(posedge i_clk); while (o_stall);
        predict_vertex(x, y, fin);
        items_sent++;
    endtask

    // Lowers valid and waits until every expected beat is back and the block is quiet.
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_beats.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_window(logic signed [CW-1:0] l, logic signed [CW-1:0] b,
                                logic signed [CW-1:0] r, logic signed [CW-1:0] t);
        logic signed [CW-1:0] vals [4];
        logic [1:0]           idx [4];
        vals = '{l, b, r, t};
        idx  = '{REG_LEFT, REG_BOTTOM, REG_RIGHT, REG_TOP};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we   <= 1'b0;
        win_left   = l;
        win_bottom = b;
        win_right  = r;
        win_top    = t;
    endtask

    function automatic logic signed [CW-1:0] pick(longint lo, longint hi);
        longint v;
        if (lo < longint'(MINC)) lo = longint'(MINC);
        if (hi > longint'(MAXC)) hi = longint'(MAXC);
        v = lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1));
        return v[CW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] rand_coord(logic signed [CW-1:0] lo,
                                                        logic signed [CW-1:0] hi);
        longint span;
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        span = (longint'(hi) - longint'(lo)) / 2 + 1;
        if (span < 0) span = -span;
        return pick(longint'(lo) - span, longint'(hi) + span);
    endfunction

    task automatic send_polygon(int nv);
        for (int k = 0; k < nv; k++)
            send_vertex(rand_coord(win_left, win_right),
                        rand_coord(win_bottom, win_top), k == nv - 1);
    endtask

    task automatic test_default_window();
        // Square inside, square enclosing the window, fully outside, single vertices inside and outside.
        send_vertex(32'sd6553600, 32'sd6553600, 1'b0);
        send_vertex(32'sd13107200, 32'sd6553600, 1'b0);
        send_vertex(32'sd13107200, 32'sd13107200, 1'b0);
        send_vertex(32'sd6553600, 32'sd13107200, 1'b1);
        send_vertex(32'sd0, 32'sd0, 1'b0);
        send_vertex(32'sd26214400, 32'sd0, 1'b0);
        send_vertex(32'sd26214400, 32'sd26214400, 1'b0);
        send_vertex(32'sd0, 32'sd26214400, 1'b1);
        send_vertex(-32'sd100, 32'sd0, 1'b0);
        send_vertex(-32'sd5, 32'sd7, 1'b1);
        send_vertex(32'sd9999999, 32'sd9999999, 1'b1);
        send_vertex(32'sd0, 32'sd0, 1'b1);
        // Vertices on the boundary count as inside.
        send_vertex(32'sd3276800, 32'sd3276800, 1'b0);
        send_vertex(32'sd19660800, 32'sd19660800, 1'b1);
        // Coordinate extremes.
        send_vertex(MINC, MINC, 1'b0);
        send_vertex(MAXC, MINC, 1'b0);
        send_vertex(MAXC, MAXC, 1'b0);
        send_vertex(MINC, MAXC, 1'b1);
        send_vertex(32'sd10000000, MAXC, 1'b0);
        send_vertex(32'sd10000000, MINC, 1'b1);
    endtask

    task automatic test_window_change_mid_polygon();
        send_vertex(32'sd1000000, 32'sd8000000, 1'b0);
        send_vertex(32'sd16000000, 32'sd2000000, 1'b0);
        drain();
        write_window(32'sd0, -32'sd5000000, 32'sd9000000, 32'sd5000000);
        send_vertex(32'sd12000000, 32'sd12000000, 1'b1);
    endtask

    task automatic test_window_extremes();
        drain();
        write_window(MINC, MINC, MAXC, MAXC);
        send_vertex(MINC, MAXC, 1'b0);
        send_vertex(MAXC, MINC, 1'b0);
        send_vertex(32'sd0, 32'sd0, 1'b1);
        drain();
        // Inverted window: nothing survives.
        write_window(MAXC, MAXC, MINC, MINC);
        send_polygon(4);
        drain();
        write_window(32'sd10, -32'sd10, -32'sd10, 32'sd10);
        send_polygon(3);
        drain();
        write_window(32'sd3276800, 32'sd3276800, 32'sd19660800, 32'sd19660800);
    endtask

    task automatic test_random_polygons();
        logic signed [CW-1:0] l, b, w, h;
        int                   nv;
        while (items_sent < RAND_ITEMS) begin
            if ($urandom_range(0, 11) == 0) begin
                drain();
                l = pick(-32'sd1000000000, 32'sd1000000000);
                b = pick(-32'sd1000000000, 32'sd1000000000);
                w = pick(0, 32'sd500000000);
                h = pick(0, 32'sd500000000);
                write_window(l, b, l + w, b + h);
            end
            calm = ($urandom_range(0, 5) == 0);
            nv = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 8);
            send_polygon(nv);
            if (items_sent > RAND_ITEMS / 2 && items_sent < RAND_ITEMS / 2 + 10)
                drain();
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= REG_LEFT;
        i_cfg_data     <= '0;
        i_valid        <= 1'b0;
        i_vertex_x     <= '0;
        i_vertex_y     <= '0;
        i_final_vertex <= 1'b0;
        i_stall        <= 1'b0;
        errors     = 0;
        cycles     = 0;
        items_sent = 0;
        calm       = 1'b0;
        win_left   = 32'sd3276800;
        win_bottom = 32'sd3276800;
        win_right  = 32'sd19660800;
        win_top    = 32'sd19660800;
        for (int s = 0; s < NSTAGE; s++) begin
            stg_first_x[s] = '0; stg_first_y[s] = '0;
            stg_prev_x[s]  = '0; stg_prev_y[s]  = '0;
            stg_started[s] = 1'b0;
        end
        any_out = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_window();
        test_window_change_mid_polygon();
        test_window_extremes();
        test_random_polygons();
        drain();

        if (errors == 0)
            $display("rect_polygon_clipper: match");
        else
            $display("rect_polygon_clipper: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
design/rpc_pkg.sv
design/rpc_xunit.sv
design/rpc_dp.sv
design/rpc_ctrl.sv
design/rect_polygon_clipper.sv
design/rpc_checker.sv
verif/rect_polygon_clipper_tb.sv
